// ===== src/bba_pkg.sv =====
// Shared types and codes for the bus address allocator.
// No dependencies.
package bba_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [6:0] free_address;
	} bba_req_t;

	typedef struct packed {
		logic [6:0] granted_address;
		logic       full_res;
	} bba_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} bba_state_t;

endpackage

// ===== src/bus_address_allocator.sv =====
// Bus address allocator: next-fit search over a used-address bitmap.
// Free: result strobed in the cycle after the transfer; busy never rises, so frees run every cycle.
// Allocate: one bitmap bit tested per cycle by a single index/compare unit until a free
//   bit is found or all are; busy drops in the strobe cycle, which can take the next transfer.
// Reset (arst_n low) clears the whole bitmap at once and sets the pointer to 1.
// Results are strobed on done for one cycle; the receiver cannot stall.
module bus_address_allocator
	import bba_pkg::*;
#(
	parameter int ADDRESS_SLOTS = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  bba_req_t req,
	output logic     done,
	output bba_rsp_t rsp
);

	localparam int AW = $clog2(ADDRESS_SLOTS);
	localparam int CW = (AW > 7) ? AW : 7;
	localparam logic [AW-1:0] MAX_ADDR = AW'(ADDRESS_SLOTS - 1);
	localparam logic [AW-1:0] LAST_CNT = AW'(ADDRESS_SLOTS - 2);

	bba_state_t          state_q;
	logic [ADDRESS_SLOTS-1:0] used_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       scan_q;
	logic [AW-1:0]       cnt_q;
	logic                done_q;
	bba_rsp_t            rsp_q;

	logic          accept;
	logic [CW-1:0] fa_c;
	logic [CW-1:0] scan_c;
	logic          free_ok;
	logic          bit_used;

	assign accept   = start && (state_q == ST_IDLE);
	assign fa_c     = CW'(req.free_address);
	assign scan_c   = CW'(scan_q);
	assign free_ok  = (fa_c != '0) && (fa_c <= CW'(MAX_ADDR));
	assign bit_used = used_q[scan_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			ptr_q   <= AW'(1);
			scan_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_FREE) begin
							if (free_ok)
								used_q[fa_c[AW-1:0]] <= 1'b0;
							rsp_q  <= '0;
							done_q <= 1'b1;
						end else begin
							// pointer out of range restarts the scan at 1
							if (ptr_q == '0 || ptr_q > MAX_ADDR)
								scan_q <= AW'(1);
							else
								scan_q <= ptr_q;
							cnt_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!bit_used) begin
						used_q[scan_q]        <= 1'b1;
						ptr_q                 <= scan_q;
						rsp_q.granted_address <= scan_c[6:0];
						rsp_q.full_res        <= 1'b0;
						done_q                <= 1'b1;
						state_q               <= ST_IDLE;
					end else if (cnt_q == LAST_CNT) begin
						rsp_q.granted_address <= '0;
						rsp_q.full_res        <= 1'b1;
						done_q                <= 1'b1;
						state_q               <= ST_IDLE;
					end else begin
						scan_q <= (scan_q >= MAX_ADDR) ? AW'(1) : scan_q + AW'(1);
						cnt_q  <= cnt_q + AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// a result only follows a transfer or a scan
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start) || $past(busy))
		else $error("result strobe without a cause");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.full_res |-> rsp.granted_address == '0)
		else $error("full result with nonzero address");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cnt_q <= LAST_CNT && scan_q != '0)
		else $error("scan out of bounds");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy && bit_used && cnt_q != LAST_CNT |=> busy && cnt_q == $past(cnt_q) + AW'(1))
		else $error("scan counter did not advance");

endmodule

// ===== sim/tb_bus_address_allocator.sv =====
// Self-checking testbench for bus_address_allocator: directed table, then random traffic.
// Results checked field by field vs typed table rows, else a next-fit bitmap predictor.
// Depends on bba_pkg (src/bba_pkg.sv) and the allocator RTL.
`timescale 1ns / 1ps

module tb_bus_address_allocator;
	import bba_pkg::*;

	localparam int ADDRESS_SLOTS = 128;
	localparam int MAX_ADDR      = ADDRESS_SLOTS - 1;
	localparam int RAND_ITEMS    = 1200;
	localparam int QUIET_LIMIT   = 8 * ADDRESS_SLOTS + 64;
	localparam bba_rsp_t NO_GRANT = '{granted_address: 7'd0, full_res: 1'b0};

	typedef struct packed {
		bba_req_t r;
		logic     typed;
		bba_rsp_t t;
	} dir_row_t;

	typedef enum int {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

	localparam int N_DIR = 16;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{'{CMD_ALLOC, 7'h00}, 1'b1, '{7'd1, 1'b0}},
		'{'{CMD_ALLOC, 7'h7F}, 1'b1, '{7'd2, 1'b0}},
		'{'{CMD_FREE,  7'h00}, 1'b1, NO_GRANT},
		'{'{CMD_FREE,  7'd100}, 1'b1, NO_GRANT},
		'{'{CMD_FREE,  7'h7F}, 1'b1, NO_GRANT},
		'{'{CMD_ALLOC, 7'h55}, 1'b0, NO_GRANT},
		'{'{CMD_FREE,  7'h01}, 1'b1, NO_GRANT},
		'{'{CMD_FREE,  7'h02}, 1'b1, NO_GRANT},
		'{'{CMD_ALLOC, 7'h2A}, 1'b0, NO_GRANT},
		'{'{CMD_FREE,  7'h03}, 1'b1, NO_GRANT},
		'{'{CMD_FREE,  7'h04}, 1'b1, NO_GRANT},
		'{'{CMD_ALLOC, 7'h00}, 1'b0, NO_GRANT},
		'{'{CMD_ALLOC, 7'h7F}, 1'b0, NO_GRANT},
		'{'{CMD_FREE,  7'h55}, 1'b1, NO_GRANT},
		'{'{CMD_FREE,  7'h2A}, 1'b1, NO_GRANT},
		'{'{CMD_ALLOC, 7'h00}, 1'b0, NO_GRANT}
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	bba_req_t req = '0;
	logic     done;
	bba_rsp_t rsp;

	// expectation attached to the request currently on the bus
	logic     row_typed = 1'b0;
	bba_rsp_t row_rsp = '0;

	logic [ADDRESS_SLOTS-1:0] taken;
	int                       scan_ptr;
	bba_rsp_t                 grant_q [$];
	int                       errors = 0;
	int                       quiet_cycles = 0;

	bus_address_allocator #(.ADDRESS_SLOTS(ADDRESS_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bba_rsp_t predict_grant(bba_req_t r);
		bba_rsp_t g;
		int a;
		int n;
		g = NO_GRANT;
		if (r.cmd == CMD_FREE) begin
			if (r.free_address != 0 && int'(r.free_address) <= MAX_ADDR)
				taken[r.free_address] = 1'b0;
			return g;
		end
		a = scan_ptr;
		if (a == 0 || a > MAX_ADDR)
			a = 1;
		for (n = 0; n < MAX_ADDR; n++) begin
			if (!taken[a]) begin
				taken[a] = 1'b1;
				scan_ptr = a;
				g.granted_address = a[6:0];
				return g;
			end
			a = (a >= MAX_ADDR) ? 1 : a + 1;
		end
		g.full_res = 1'b1;
		return g;
	endfunction

	// check results first, then record the transfer of this edge
	always @(posedge clk) begin
		bba_rsp_t want;
		bba_rsp_t pred;
		if (arst_n) begin
			if (done) begin
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected result granted_address %0d full_res %0d",
						$time, rsp.granted_address, rsp.full_res);
					errors++;
				end else begin
					want = grant_q[0];
					grant_q.delete(0);
					if (rsp.granted_address !== want.granted_address) begin
						$display("%0t: granted_address expected %0d actual %0d",
							$time, want.granted_address, rsp.granted_address);
						errors++;
					end
					if (rsp.full_res !== want.full_res) begin
						$display("%0t: full_res expected %0d actual %0d",
							$time, want.full_res, rsp.full_res);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				pred = predict_grant(req);
				grant_q.insert(grant_q.size(), row_typed ? row_rsp : pred);
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(bba_req_t r, logic typed, bba_rsp_t t, bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < 19) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req       <= r;
		row_typed <= typed;
		row_rsp   <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (grant_q.size() != 0);
	endtask

	initial begin
		bba_req_t  r;
		mix_mode_t mode;
		int        alloc_pct;
		int        len;
		int        n_sent;
		int        phase;
		int        a;
		int        j;
		int        k;

		taken    = '0;
		scan_ptr = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIR; k++)
			send_item(DIR_ROWS[k].r, DIR_ROWS[k].typed, DIR_ROWS[k].t, 1'b1);

		n_sent = 0;
		phase  = 0;
		while (n_sent < RAND_ITEMS) begin
			// first phase only allocates, so the map runs full early on
			if (phase == 0) begin
				mode = MODE_FILL;
				len  = 140;
			end else begin
				mode = mix_mode_t'($urandom_range(1, 3));
				len  = $urandom_range(40, 120);
			end
			case (mode)
				MODE_FILL:   alloc_pct = 100;
				MODE_GROW:   alloc_pct = 85;
				MODE_SHRINK: alloc_pct = 30;
				default:     alloc_pct = 50;
			endcase
			for (k = 0; k < len; k++) begin
				r.cmd          = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
				r.free_address = 7'($urandom_range(127));
				if (r.cmd == CMD_FREE && $urandom_range(99) < 80) begin
					// mostly release an address that is in use
					a = $urandom_range(1, MAX_ADDR);
					for (j = 0; j < MAX_ADDR && !taken[a]; j++)
						a = (a >= MAX_ADDR) ? 1 : a + 1;
					r.free_address = a[6:0];
				end else if (r.cmd == CMD_FREE && $urandom_range(3) == 0) begin
					r.free_address = 7'd0;
				end
				send_item(r, 1'b0, NO_GRANT, !(n_sent >= 500 && n_sent < 700));
				n_sent++;
			end
			if (phase == 0 || $urandom_range(2) == 0)
				drain_results();
			phase++;
		end

		drain_results();
		repeat (ADDRESS_SLOTS + 8) @(posedge clk);
		if (errors == 0 && grant_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== bus_address_allocator.f =====
src/bba_pkg.sv
src/bus_address_allocator.sv
sim/tb_bus_address_allocator.sv
